// ===== sv/cholsv_pkg.sv =====
// ============================================================================
// Cholesky solver package
// Shared word types, codes, state encodings and saturation helper.
// ============================================================================
`default_nettype none

package cholsv_pkg;

    localparam int MAX_DIM_DEF   = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam logic [4:0] SIZE_RESET = 5'd16;

    localparam logic [1:0] MODE_MAT   = 2'd0;
    localparam logic [1:0] MODE_RHS   = 2'd1;
    localparam logic [1:0] MODE_SOLVE = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [3:0]         row;
        logic [3:0]         column;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic [3:0]         index;
        logic signed [31:0] solution;
        logic               last;
        logic               error;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_DOT_RD,
        S_DOT_MUL,
        S_DOT_ACC,
        S_BASE_RD,
        S_BASE_EX,
        S_UNIT_WAIT,
        S_WRITE,
        S_CLEAR,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_WAIT
    } t_state;

    typedef enum logic [1:0] {
        OP_OFF,
        OP_DIAG,
        OP_FWD,
        OP_BWD
    } t_op;

    localparam logic signed [64:0] SAT_MAX = 65'sd2147483647;
    localparam logic signed [64:0] SAT_MIN = -65'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/cholsv_div.sv =====
// ============================================================================
// Fixed-point divider
// Restoring division of (num << FRAC_BITS) by a positive divisor, one
// quotient bit per cycle, truncated toward zero and saturated to 32 bits.
// ============================================================================
`default_nettype none

module cholsv_div #(
    parameter int FRAC_BITS = cholsv_pkg::FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_num,
    input  wire logic signed [31:0] i_den,
    output logic                    o_done,
    output logic signed [31:0]      o_quot
);

    localparam int DW   = 32 + FRAC_BITS;
    localparam int CNTW = $clog2(DW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_dvd;
    logic [31:0]     r_rem;
    logic [31:0]     r_den;
    logic            r_neg;

    logic [31:0] mag;
    logic [32:0] rem_sh;
    logic        qbit;
    logic [32:0] rem_nx;

    assign mag    = i_num[31] ? (~i_num + 32'd1) : i_num;
    assign rem_sh = {r_rem, r_dvd[DW-1]};
    assign qbit   = (rem_sh >= {1'b0, r_den});
    assign rem_nx = qbit ? (rem_sh - {1'b0, r_den}) : rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= CNTW'(r_cnt + 1'b1);
                if (r_cnt == CNTW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {mag, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[31];
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DW-2:0], qbit};
            r_rem <= rem_nx[31:0];
        end
    end

    always_comb begin
        if (!r_neg) begin
            if (r_dvd > {{FRAC_BITS{1'b0}}, 32'h7FFF_FFFF}) begin
                o_quot = 32'sh7FFF_FFFF;
            end else begin
                o_quot = r_dvd[31:0];
            end
        end else begin
            if (r_dvd > {{FRAC_BITS{1'b0}}, 32'h8000_0000}) begin
                o_quot = 32'sh8000_0000;
            end else begin
                o_quot = ~r_dvd[31:0] + 32'd1;
            end
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== sv/cholsv_sqrt.sv =====
// ============================================================================
// Fixed-point square root
// Digit-by-digit integer square root of (p << FRAC_BITS), one result bit
// per cycle.
// ============================================================================
`default_nettype none

module cholsv_sqrt #(
    parameter int FRAC_BITS = cholsv_pkg::FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_rad,
    output logic                    o_done,
    output logic signed [31:0]      o_root
);

    localparam int VW   = 32 + FRAC_BITS;
    localparam int RW   = VW + (VW % 2);
    localparam int HW   = RW / 2;
    localparam int CNTW = $clog2(HW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [RW-1:0]   r_v;
    logic [HW+1:0]   r_rem;
    logic [HW-1:0]   r_root;

    logic [HW+3:0] rem_t;
    logic [HW+3:0] trial;
    logic          take;

    assign rem_t = {r_rem, r_v[RW-1:RW-2]};
    assign trial = {2'b00, r_root, 2'b01};
    assign take  = (rem_t >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= CNTW'(r_cnt + 1'b1);
                if (r_cnt == CNTW'(HW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= RW'({i_rad, {FRAC_BITS{1'b0}}});
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_v    <= {r_v[RW-3:0], 2'b00};
            r_rem  <= take ? (HW+2)'(rem_t - trial) : (HW+2)'(rem_t);
            r_root <= {r_root[HW-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_root = 32'(r_root);

endmodule

`default_nettype wire

// ===== sv/cholesky_linear_solver_top.sv =====
// ============================================================================
// Cholesky linear solver
// Loads a symmetric positive definite matrix and a right-hand side into
// on-chip memories, factors in place, substitutes and returns the solution.
//
//   Channel   Direction  Signals                         Word
//   input     in         i_in_valid / o_in_ready         t_in_word
//   output    out        o_out_valid / i_out_ready       t_out_word
//   config    in         i_cfg_we / i_cfg_wdata          size_in_use
//
// Load words are taken one per cycle while idle. A solve word holds the input
// for the whole computation, cubic in the size in use: per element a setup, a
// read, multiply and accumulate per multiply-accumulate term, a base read, a
// divider or square-root run and a write, plus a clear per cleared upper entry.
// Each solution word is then read, registered and held until it is accepted.
// Reset is synchronous and clears control only; memories are not cleared.
// ============================================================================
`default_nettype none

module cholesky_linear_solver_top #(
    parameter int MAX_DIM   = cholsv_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = cholsv_pkg::FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire cholsv_pkg::t_in_word i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output cholsv_pkg::t_out_word     o_out_word,
    input  wire logic                 i_cfg_we,
    input  wire logic [4:0]           i_cfg_wdata
);

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW = $clog2(MAX_DIM + 1);
    localparam int MD = MAX_DIM * MAX_DIM;
    localparam int AW = (MD > 1) ? $clog2(MD) : 1;
    localparam int VW = IW + 1;

    function automatic logic [AW-1:0] mat_addr(input int r, input int c);
        return AW'(r * MAX_DIM + c);
    endfunction

    function automatic logic [VW-1:0] vec_addr(input logic sel, input int idx);
        return {sel, IW'(idx)};
    endfunction

    cholsv_pkg::t_state r_state, n_state;
    cholsv_pkg::t_op    r_op;

    logic [4:0]    r_size;
    logic [CW-1:0] r_n, r_i, r_j, r_k, r_kend;
    logic          r_err;
    logic          r_o_vld;
    cholsv_pkg::t_out_word r_o_word;

    logic signed [63:0] r_acc;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_res;

    logic signed [31:0] r_mat [MD];
    logic signed [31:0] r_vec [2**VW];
    logic signed [31:0] r_mat_qa, r_mat_qb, r_vec_q;

    logic               mat_we;
    logic [AW-1:0]      mat_waddr, mat_ra_a, mat_ra_b;
    logic signed [31:0] mat_wdata;
    logic               vec_we;
    logic [VW-1:0]      vec_waddr, vec_ra;
    logic signed [31:0] vec_wdata;
    logic               div_start, sqrt_start;

    logic               in_acc;
    logic [CW-1:0]      kstart, kend_c, n_clamp;
    logic               vec_op, k_last, out_last;
    logic               more_off, more_cols, fwd_more, bwd_more, clr_more;
    logic signed [31:0] base, opa;
    logic signed [64:0] wide;
    logic signed [31:0] diff_sat;
    logic               nonpos;
    logic signed [63:0] prod_c;
    logic               div_done, sqrt_done, unit_done;
    logic signed [31:0] div_quot, sqrt_root;

    assign o_in_ready = (r_state == cholsv_pkg::S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    assign n_clamp = (r_size == 5'd0) ? CW'(1) :
                     ((int'(r_size) > MAX_DIM) ? CW'(MAX_DIM) : CW'(r_size));

    assign vec_op = (r_op == cholsv_pkg::OP_FWD) || (r_op == cholsv_pkg::OP_BWD);
    assign kstart = (r_op == cholsv_pkg::OP_BWD) ? CW'(r_i + 1'b1) : '0;

    always_comb begin
        case (r_op)
            cholsv_pkg::OP_OFF: kend_c = r_j;
            cholsv_pkg::OP_BWD: kend_c = r_n;
            default:            kend_c = r_i;
        endcase
    end

    assign k_last    = (CW'(r_k + 1'b1) == r_kend);
    assign out_last  = (CW'(r_k + 1'b1) == r_n);
    assign more_off  = (CW'(r_j + 1'b1) < r_i);
    assign more_cols = (CW'(r_i + 1'b1) < r_n);
    assign fwd_more  = (CW'(r_i + 1'b1) < r_n);
    assign bwd_more  = (r_i != '0);
    assign clr_more  = (CW'(r_j + 1'b1) < r_n);

    assign base     = vec_op ? r_vec_q : r_mat_qa;
    assign wide     = $signed({{33{base[31]}}, base}) - $signed({r_acc[63], r_acc});
    assign diff_sat = cholsv_pkg::sat32(wide);
    assign nonpos   = wide[64] || (wide == '0);

    assign opa    = vec_op ? r_vec_q : r_mat_qb;
    assign prod_c = opa * r_mat_qa;

    assign unit_done = div_done || sqrt_done;

    cholsv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (diff_sat),
        .i_den   (r_mat_qb),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    cholsv_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (diff_sat),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    // Every element is read, computed and written back before the next
    // element issues its reads, so no two accesses to one entry overlap.
    always_ff @(posedge i_clk) begin
        if (mat_we) begin
            r_mat[mat_waddr] <= mat_wdata;
        end
        r_mat_qa <= r_mat[mat_ra_a];
        r_mat_qb <= r_mat[mat_ra_b];
    end

    always_ff @(posedge i_clk) begin
        if (vec_we) begin
            r_vec[vec_waddr] <= vec_wdata;
        end
        r_vec_q <= r_vec[vec_ra];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            cholsv_pkg::S_IDLE: begin
                if (in_acc && (i_in_word.mode == cholsv_pkg::MODE_SOLVE)) begin
                    n_state = cholsv_pkg::S_SETUP;
                end
            end
            cholsv_pkg::S_SETUP: begin
                n_state = (kstart == kend_c) ? cholsv_pkg::S_BASE_RD : cholsv_pkg::S_DOT_RD;
            end
            cholsv_pkg::S_DOT_RD:  n_state = cholsv_pkg::S_DOT_MUL;
            cholsv_pkg::S_DOT_MUL: n_state = cholsv_pkg::S_DOT_ACC;
            cholsv_pkg::S_DOT_ACC: begin
                n_state = k_last ? cholsv_pkg::S_BASE_RD : cholsv_pkg::S_DOT_RD;
            end
            cholsv_pkg::S_BASE_RD: n_state = cholsv_pkg::S_BASE_EX;
            cholsv_pkg::S_BASE_EX: begin
                if ((r_op == cholsv_pkg::OP_DIAG) && nonpos) begin
                    n_state = cholsv_pkg::S_OUT_RD;
                end else begin
                    n_state = cholsv_pkg::S_UNIT_WAIT;
                end
            end
            cholsv_pkg::S_UNIT_WAIT: begin
                if (unit_done) begin
                    n_state = cholsv_pkg::S_WRITE;
                end
            end
            cholsv_pkg::S_WRITE: begin
                case (r_op)
                    cholsv_pkg::OP_DIAG: begin
                        n_state = more_cols ? cholsv_pkg::S_CLEAR : cholsv_pkg::S_SETUP;
                    end
                    cholsv_pkg::OP_BWD: begin
                        n_state = bwd_more ? cholsv_pkg::S_SETUP : cholsv_pkg::S_OUT_RD;
                    end
                    default: n_state = cholsv_pkg::S_SETUP;
                endcase
            end
            cholsv_pkg::S_CLEAR: begin
                n_state = clr_more ? cholsv_pkg::S_CLEAR : cholsv_pkg::S_SETUP;
            end
            cholsv_pkg::S_OUT_RD: n_state = cholsv_pkg::S_OUT_LD;
            cholsv_pkg::S_OUT_LD: n_state = cholsv_pkg::S_OUT_WAIT;
            cholsv_pkg::S_OUT_WAIT: begin
                if (i_out_ready) begin
                    n_state = out_last ? cholsv_pkg::S_IDLE : cholsv_pkg::S_OUT_RD;
                end
            end
            default: n_state = cholsv_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        mat_we     = 1'b0;
        mat_waddr  = '0;
        mat_wdata  = '0;
        mat_ra_a   = '0;
        mat_ra_b   = '0;
        vec_we     = 1'b0;
        vec_waddr  = '0;
        vec_wdata  = '0;
        vec_ra     = '0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        case (r_state)
            cholsv_pkg::S_IDLE: begin
                mat_waddr = mat_addr(int'(i_in_word.row), int'(i_in_word.column));
                mat_wdata = i_in_word.value;
                vec_waddr = vec_addr(1'b0, int'(i_in_word.row));
                vec_wdata = i_in_word.value;
                if (in_acc && (int'(i_in_word.row) < MAX_DIM)) begin
                    if ((i_in_word.mode == cholsv_pkg::MODE_MAT) &&
                        (int'(i_in_word.column) < MAX_DIM)) begin
                        mat_we = 1'b1;
                    end
                    if (i_in_word.mode == cholsv_pkg::MODE_RHS) begin
                        vec_we = 1'b1;
                    end
                end
            end
            cholsv_pkg::S_DOT_RD: begin
                vec_ra = vec_addr(1'b1, int'(r_k));
                case (r_op)
                    cholsv_pkg::OP_OFF: begin
                        mat_ra_a = mat_addr(int'(r_i), int'(r_k));
                        mat_ra_b = mat_addr(int'(r_j), int'(r_k));
                    end
                    cholsv_pkg::OP_BWD: begin
                        mat_ra_a = mat_addr(int'(r_k), int'(r_i));
                    end
                    default: begin
                        mat_ra_a = mat_addr(int'(r_i), int'(r_k));
                        mat_ra_b = mat_addr(int'(r_i), int'(r_k));
                    end
                endcase
            end
            cholsv_pkg::S_BASE_RD: begin
                mat_ra_b = mat_addr(int'(r_i), int'(r_i));
                case (r_op)
                    cholsv_pkg::OP_OFF: begin
                        mat_ra_a = mat_addr(int'(r_i), int'(r_j));
                        mat_ra_b = mat_addr(int'(r_j), int'(r_j));
                    end
                    cholsv_pkg::OP_DIAG: mat_ra_a = mat_addr(int'(r_i), int'(r_i));
                    cholsv_pkg::OP_FWD:  vec_ra = vec_addr(1'b0, int'(r_i));
                    default:             vec_ra = vec_addr(1'b1, int'(r_i));
                endcase
            end
            cholsv_pkg::S_BASE_EX: begin
                if (r_op == cholsv_pkg::OP_DIAG) begin
                    sqrt_start = !nonpos;
                end else begin
                    div_start = 1'b1;
                end
            end
            cholsv_pkg::S_WRITE: begin
                mat_wdata = r_res;
                vec_wdata = r_res;
                vec_waddr = vec_addr(1'b1, int'(r_i));
                case (r_op)
                    cholsv_pkg::OP_OFF: begin
                        mat_we    = 1'b1;
                        mat_waddr = mat_addr(int'(r_i), int'(r_j));
                    end
                    cholsv_pkg::OP_DIAG: begin
                        mat_we    = 1'b1;
                        mat_waddr = mat_addr(int'(r_i), int'(r_i));
                    end
                    default: vec_we = 1'b1;
                endcase
            end
            cholsv_pkg::S_CLEAR: begin
                mat_we    = 1'b1;
                mat_waddr = mat_addr(int'(r_i), int'(r_j));
            end
            cholsv_pkg::S_OUT_RD: begin
                vec_ra = vec_addr(1'b1, int'(r_k));
            end
            default: begin
                mat_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cholsv_pkg::S_IDLE;
            r_size  <= cholsv_pkg::SIZE_RESET;
            r_o_vld <= 1'b0;
            r_err   <= 1'b0;
            r_op    <= cholsv_pkg::OP_DIAG;
            r_n     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_kend  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            case (r_state)
                cholsv_pkg::S_IDLE: begin
                    if (in_acc && (i_in_word.mode == cholsv_pkg::MODE_SOLVE)) begin
                        r_n   <= n_clamp;
                        r_op  <= cholsv_pkg::OP_DIAG;
                        r_i   <= '0;
                        r_j   <= '0;
                        r_err <= 1'b0;
                    end
                end
                cholsv_pkg::S_SETUP: begin
                    r_k    <= kstart;
                    r_kend <= kend_c;
                end
                cholsv_pkg::S_DOT_ACC: begin
                    r_k <= CW'(r_k + 1'b1);
                end
                cholsv_pkg::S_BASE_EX: begin
                    if ((r_op == cholsv_pkg::OP_DIAG) && nonpos) begin
                        r_err <= 1'b1;
                        r_k   <= '0;
                    end
                end
                cholsv_pkg::S_WRITE: begin
                    case (r_op)
                        cholsv_pkg::OP_OFF: begin
                            if (more_off) begin
                                r_j <= CW'(r_j + 1'b1);
                            end else begin
                                r_op <= cholsv_pkg::OP_DIAG;
                            end
                        end
                        cholsv_pkg::OP_DIAG: begin
                            if (more_cols) begin
                                r_j <= CW'(r_i + 1'b1);
                            end else begin
                                r_op <= cholsv_pkg::OP_FWD;
                                r_i  <= '0;
                            end
                        end
                        cholsv_pkg::OP_FWD: begin
                            if (fwd_more) begin
                                r_i <= CW'(r_i + 1'b1);
                            end else begin
                                r_op <= cholsv_pkg::OP_BWD;
                            end
                        end
                        default: begin
                            if (bwd_more) begin
                                r_i <= CW'(r_i - 1'b1);
                            end else begin
                                r_k <= '0;
                            end
                        end
                    endcase
                end
                cholsv_pkg::S_CLEAR: begin
                    if (clr_more) begin
                        r_j <= CW'(r_j + 1'b1);
                    end else begin
                        r_i  <= CW'(r_i + 1'b1);
                        r_j  <= '0;
                        r_op <= cholsv_pkg::OP_OFF;
                    end
                end
                cholsv_pkg::S_OUT_LD: begin
                    r_o_vld <= 1'b1;
                end
                cholsv_pkg::S_OUT_WAIT: begin
                    if (i_out_ready) begin
                        r_o_vld <= 1'b0;
                        r_k     <= CW'(r_k + 1'b1);
                    end
                end
                default: begin
                    r_o_vld <= r_o_vld;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            cholsv_pkg::S_SETUP:   r_acc  <= '0;
            cholsv_pkg::S_DOT_MUL: r_prod <= prod_c;
            cholsv_pkg::S_DOT_ACC: r_acc  <= r_acc + (r_prod >>> FRAC_BITS);
            cholsv_pkg::S_UNIT_WAIT: begin
                if (unit_done) begin
                    r_res <= (r_op == cholsv_pkg::OP_DIAG) ? sqrt_root : div_quot;
                end
            end
            cholsv_pkg::S_OUT_LD: begin
                r_o_word.index    <= 4'(r_k);
                r_o_word.solution <= r_err ? 32'sd0 : r_vec_q;
                r_o_word.last     <= out_last;
                r_o_word.error    <= r_err;
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    assign o_out_valid = r_o_vld;
    assign o_out_word  = r_o_word;

endmodule

`default_nettype wire

// ===== sv/cholsv_checker.sv =====
// ============================================================================
// Cholesky solver port checker
// Watches the top-level input and output channels for ordering and handshake rules.
// ============================================================================
`default_nettype none

module cholsv_checker (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_ready,
    input wire cholsv_pkg::t_in_word  i_in_word,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_ready,
    input wire cholsv_pkg::t_out_word o_out_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)))
        else $error("Output word changed or dropped while stalled.");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("Input accepted while a solution word is pending.");

    a_solve_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in_word.mode == cholsv_pkg::MODE_SOLVE))
        |=> !o_in_ready)
        else $error("Input still ready after a solve word.");

    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> !o_out_valid)
        else $error("Solution word presented directly after a transfer.");

endmodule

bind cholesky_linear_solver_top cholsv_checker u_cholsv_checker (.*);

`default_nettype wire
